// ----- sv/rwl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwl_pkg
// Codes and fixed widths shared by the reader-writer lock manager.
// ----------------------------------------------------------------------------
package rwl_pkg;

	localparam int REQUESTER_COUNT = 256;
	localparam int REQ_W           = $clog2(REQUESTER_COUNT);
	localparam int RESULT_LIMIT    = 16;
	localparam int BURST_W         = $clog2(RESULT_LIMIT + 1);

	typedef logic [2:0] cmd_t;
	typedef logic [2:0] outcome_t;
	typedef logic [1:0] mode_t;

	localparam cmd_t CMD_LOCK_READ    = 3'd0;
	localparam cmd_t CMD_TRY_READ     = 3'd1;
	localparam cmd_t CMD_LOCK_WRITE   = 3'd2;
	localparam cmd_t CMD_TRY_WRITE    = 3'd3;
	localparam cmd_t CMD_READ_UNLOCK  = 3'd4;
	localparam cmd_t CMD_WRITE_UNLOCK = 3'd5;
	localparam cmd_t CMD_UNLOCK       = 3'd6;
	localparam cmd_t CMD_UPGRADE      = 3'd7;

	localparam outcome_t OC_GRANT    = 3'd0;
	localparam outcome_t OC_QUEUED   = 3'd1;
	localparam outcome_t OC_REFUSED  = 3'd2;
	localparam outcome_t OC_WOKEN    = 3'd3;
	localparam outcome_t OC_RELEASED = 3'd4;
	localparam outcome_t OC_ERROR    = 3'd5;

	localparam mode_t MODE_FREE  = 2'd0;
	localparam mode_t MODE_READ  = 2'd1;
	localparam mode_t MODE_WRITE = 2'd2;

endpackage
`default_nettype wire

// ----- sv/reader_writer_lock_arbiter.sv -----
`default_nettype none
// the first result passes the decide and load states into the output register, and
//   the read state as well when it names a waiting agent (queue read)
// the sequencer takes one request at a time and accepts no new request until the
//   results of the last are loaded; a write unlock that wakes n readers gives n results
// reset clears lock mode, reader count, queue counts and the fifo head; queue contents
//   are not cleared
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter
// Reader-writer lock manager with a fifo of waiting readers and a stack of
// waiting writers, handled by a small sequencer one request at a time.
// ----------------------------------------------------------------------------
module reader_writer_lock_arbiter
	import rwl_pkg::*;
#(
	parameter int READ_WAIT_DEPTH  = 16,
	parameter int WRITE_WAIT_DEPTH = 16,
	parameter int MAX_READERS      = 255
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [2:0]       command,
	input  wire logic [REQ_W-1:0] requester,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [REQ_W-1:0] target,
	output logic      [2:0]       outcome,
	output logic      [1:0]       prev_state,
	output logic      [7:0]       reader_total,
	output logic                  last
);

	localparam int RA_W      = (READ_WAIT_DEPTH > 1) ? $clog2(READ_WAIT_DEPTH) : 1;
	localparam int RC_W      = $clog2(READ_WAIT_DEPTH + 1);
	localparam int WA_W      = (WRITE_WAIT_DEPTH > 1) ? $clog2(WRITE_WAIT_DEPTH) : 1;
	localparam int WC_W      = $clog2(WRITE_WAIT_DEPTH + 1);
	localparam int RN_W      = $clog2(MAX_READERS + 1);
	localparam int BURST_MAX = (MAX_READERS < RESULT_LIMIT) ? MAX_READERS : RESULT_LIMIT;
	localparam int CMP_W     = (RC_W > BURST_W) ? RC_W : BURST_W;
	localparam int SUM_W     = ((RA_W > RC_W) ? RA_W : RC_W) + 1;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECIDE = 2'd1;
	localparam logic [1:0] S_READ   = 2'd2;
	localparam logic [1:0] S_LOAD   = 2'd3;

	logic [1:0]       state_q;
	cmd_t             cmd_q;
	logic [REQ_W-1:0] who_q;

	mode_t            mode_q;
	logic [RN_W-1:0]  rcount_q;
	logic [RC_W-1:0]  rwc_q;
	logic [RA_W-1:0]  rhead_q;
	logic [WC_W-1:0]  wwc_q;
	logic [BURST_W-1:0] burst_left_q;

	outcome_t         res_outcome_q;
	mode_t            res_prev_q;
	logic             res_from_ram_q;
	logic             res_rsel_q;

	logic             out_valid_q;
	logic [REQ_W-1:0] target_q;
	outcome_t         outcome_q;
	mode_t            prev_q;
	logic [7:0]       total_q;
	logic             last_q;

	// decision for the request in hand
	mode_t            d_mode;
	logic [RN_W-1:0]  d_rcount;
	logic [RC_W-1:0]  d_rwc;
	logic [WC_W-1:0]  d_wwc;
	outcome_t         d_outcome;
	mode_t            d_prev;
	logic             d_r_push;
	logic             d_w_push;
	logic             d_w_pop;
	logic             d_r_wake;
	logic [BURST_W-1:0] d_n;

	logic             rd_full;
	logic             wr_full;
	logic             rsat;
	logic [CMP_W-1:0] rwc_ext;
	logic [SUM_W-1:0] r_sum;
	logic [SUM_W-1:0] r_wrap;
	logic [RA_W-1:0]  r_push_addr;
	logic [WC_W-1:0]  wwc_dec;
	logic [RA_W-1:0]  rhead_inc;
	logic [RN_W+7:0]  rcount_ext;

	logic             slot_free;
	logic             more;
	logic             r_wr_en;
	logic             w_wr_en;
	logic             r_rd_en;
	logic             w_rd_en;
	logic [REQ_W-1:0] r_rd_data;
	logic [REQ_W-1:0] w_rd_data;
	logic [REQ_W-1:0] res_target;

	assign rd_full = (rwc_q == RC_W'(READ_WAIT_DEPTH));
	assign wr_full = (wwc_q == WC_W'(WRITE_WAIT_DEPTH));
	assign rsat    = (rcount_q >= RN_W'(MAX_READERS));
	assign rwc_ext = CMP_W'(rwc_q);
	assign wwc_dec = wwc_q - 1'b1;

	// fifo tail sits count entries past the head, wrapped once
	assign r_sum       = SUM_W'(rhead_q) + SUM_W'(rwc_q);
	assign r_wrap      = (r_sum >= SUM_W'(READ_WAIT_DEPTH)) ?
		r_sum - SUM_W'(READ_WAIT_DEPTH) : r_sum;
	assign r_push_addr = r_wrap[RA_W-1:0];
	assign rhead_inc   = (rhead_q == RA_W'(READ_WAIT_DEPTH - 1)) ?
		'0 : rhead_q + RA_W'(1);

	always_comb begin
		d_mode    = mode_q;
		d_rcount  = rcount_q;
		d_rwc     = rwc_q;
		d_wwc     = wwc_q;
		d_outcome = OC_ERROR;
		d_prev    = mode_q;
		d_r_push  = 1'b0;
		d_w_push  = 1'b0;
		d_w_pop   = 1'b0;
		d_r_wake  = 1'b0;
		d_n       = (rwc_ext > CMP_W'(BURST_MAX)) ? BURST_W'(BURST_MAX) : BURST_W'(rwc_ext);
		unique case (cmd_q)
			CMD_LOCK_READ, CMD_TRY_READ: begin
				if (mode_q != MODE_WRITE) begin
					if (!rsat) begin
						d_rcount  = rcount_q + RN_W'(1);
						d_mode    = MODE_READ;
						d_outcome = OC_GRANT;
					end
				end else if (cmd_q == CMD_TRY_READ) begin
					d_outcome = OC_REFUSED;
				end else if (!rd_full) begin
					d_r_push  = 1'b1;
					d_rwc     = rwc_q + RC_W'(1);
					d_outcome = OC_QUEUED;
				end
			end
			CMD_LOCK_WRITE, CMD_TRY_WRITE: begin
				if (mode_q == MODE_FREE) begin
					d_mode    = MODE_WRITE;
					d_outcome = OC_GRANT;
				end else if (cmd_q == CMD_TRY_WRITE) begin
					d_outcome = OC_REFUSED;
				end else if (!wr_full) begin
					d_w_push  = 1'b1;
					d_wwc     = wwc_q + WC_W'(1);
					d_outcome = OC_QUEUED;
				end
			end
			CMD_READ_UNLOCK, CMD_WRITE_UNLOCK, CMD_UNLOCK: begin
				if (mode_q == MODE_WRITE && cmd_q != CMD_READ_UNLOCK) begin
					d_prev = MODE_WRITE;
					if (wwc_q != '0) begin
						d_w_pop   = 1'b1;
						d_wwc     = wwc_dec;
						d_outcome = OC_WOKEN;
					end else if (rwc_q != '0) begin
						d_r_wake  = 1'b1;
						d_rwc     = rwc_q - RC_W'(d_n);
						d_rcount  = RN_W'(d_n);
						d_mode    = MODE_READ;
						d_outcome = OC_WOKEN;
					end else begin
						d_mode    = MODE_FREE;
						d_outcome = OC_RELEASED;
					end
				end else if (mode_q == MODE_READ && rcount_q != '0 &&
					cmd_q != CMD_WRITE_UNLOCK) begin
					d_prev   = MODE_READ;
					d_rcount = rcount_q - RN_W'(1);
					if (rcount_q != RN_W'(1)) begin
						d_outcome = OC_RELEASED;
					end else if (wwc_q != '0) begin
						d_w_pop   = 1'b1;
						d_wwc     = wwc_dec;
						d_mode    = MODE_WRITE;
						d_outcome = OC_WOKEN;
					end else begin
						d_mode    = MODE_FREE;
						d_outcome = OC_RELEASED;
					end
				end
			end
			CMD_UPGRADE: begin
				if (mode_q == MODE_READ && rcount_q != '0) begin
					if (rcount_q == RN_W'(1)) begin
						d_rcount  = '0;
						d_mode    = MODE_WRITE;
						d_outcome = OC_GRANT;
					end else if (!wr_full) begin
						d_rcount  = rcount_q - RN_W'(1);
						d_w_push  = 1'b1;
						d_wwc     = wwc_q + WC_W'(1);
						d_outcome = OC_QUEUED;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign more      = (burst_left_q != '0);

	assign r_wr_en = (state_q == S_DECIDE) && d_r_push;
	assign w_wr_en = (state_q == S_DECIDE) && d_w_push;
	assign w_rd_en = (state_q == S_DECIDE) && d_w_pop;
	assign r_rd_en = ((state_q == S_DECIDE) && d_r_wake) ||
		((state_q == S_LOAD) && slot_free && more);

	assign res_target = res_from_ram_q ? (res_rsel_q ? r_rd_data : w_rd_data) : who_q;
	assign rcount_ext = {8'b0, rcount_q};

	rwl_ram #(
		.WIDTH (REQ_W),
		.DEPTH (READ_WAIT_DEPTH)
	) u_read_fifo (
		.clk     (clk),
		.wr_en   (r_wr_en),
		.wr_addr (r_push_addr),
		.wr_data (who_q),
		.rd_en   (r_rd_en),
		.rd_addr (rhead_q),
		.rd_data (r_rd_data)
	);

	rwl_ram #(
		.WIDTH (REQ_W),
		.DEPTH (WRITE_WAIT_DEPTH)
	) u_write_stack (
		.clk     (clk),
		.wr_en   (w_wr_en),
		.wr_addr (wwc_q[WA_W-1:0]),
		.wr_data (who_q),
		.rd_en   (w_rd_en),
		.rd_addr (wwc_dec[WA_W-1:0]),
		.rd_data (w_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_FREE;
			rcount_q     <= '0;
			rwc_q        <= '0;
			rhead_q      <= '0;
			wwc_q        <= '0;
			burst_left_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (r_rd_en) begin
				rhead_q <= rhead_inc;
			end
			// in S_LOAD a free slot is refilled below
			if (out_valid_q && out_ready && state_q != S_LOAD) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					mode_q       <= d_mode;
					rcount_q     <= d_rcount;
					rwc_q        <= d_rwc;
					wwc_q        <= d_wwc;
					burst_left_q <= d_r_wake ? d_n - BURST_W'(1) : '0;
					state_q      <= (d_r_wake || d_w_pop) ? S_READ : S_LOAD;
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (more) begin
							// next woken reader, read issued this cycle
							burst_left_q <= burst_left_q - BURST_W'(1);
							state_q      <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q <= command;
			who_q <= requester;
		end
		if (state_q == S_DECIDE) begin
			res_outcome_q  <= d_outcome;
			res_prev_q     <= d_prev;
			res_from_ram_q <= d_r_wake || d_w_pop;
			res_rsel_q     <= d_r_wake;
		end
		if (state_q == S_LOAD && slot_free) begin
			target_q  <= res_target;
			outcome_q <= res_outcome_q;
			prev_q    <= res_prev_q;
			total_q   <= rcount_ext[7:0];
			last_q    <= !more;
		end
	end

	assign out_valid    = out_valid_q;
	assign target       = target_q;
	assign outcome      = outcome_q;
	assign prev_state   = prev_q;
	assign reader_total = total_q;
	assign last         = last_q;

`ifndef SYNTHESIS
	a_read_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rwc_q <= RC_W'(READ_WAIT_DEPTH))
		else $error("reader queue count beyond depth");

	a_write_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wwc_q <= WC_W'(WRITE_WAIT_DEPTH))
		else $error("writer stack count beyond depth");

	a_reader_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcount_q <= RN_W'(MAX_READERS))
		else $error("reader count beyond limit");

	a_mode_vs_readers: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_READ) == (rcount_q != '0))
		else $error("reading mode and reader count disagree");

	a_burst_only_reading: assert property (@(posedge clk) disable iff (!arst_n)
		(burst_left_q != '0) |-> (mode_q == MODE_READ && res_rsel_q))
		else $error("reader wake burst outside reading mode");
`endif

endmodule
`default_nettype wire

// ----- sv/rwl_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rwl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- test/tb_reader_writer_lock_arbiter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reader_writer_lock_arbiter
// Self-checking bench for the reader-writer lock manager. A request plan is
// built up front against a planning copy of the lock, then driven with random
// gaps. Each accepted request runs through the bench's own lock model, and
// every result transfer is checked field by field against the oldest reply due.
// ----------------------------------------------------------------------------
module tb_reader_writer_lock_arbiter;
	import rwl_pkg::*;

	localparam int RD_DEPTH    = 16;
	localparam int WR_DEPTH    = 16;
	localparam int MAX_READERS = 255;
	localparam int LIVE        = 0;
	localparam int PLAN        = 1;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 60;

	typedef logic [REQ_W-1:0] id_t;

	typedef struct packed {
		cmd_t cmd;
		id_t  who;
	} request_t;

	typedef struct packed {
		id_t        tgt;
		outcome_t   oc;
		mode_t      prev;
		logic [7:0] total;
		logic       fin;
	} reply_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	cmd_t       command = CMD_LOCK_READ;
	id_t        requester = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	id_t        target;
	outcome_t   outcome;
	mode_t      prev_state;
	logic [7:0] reader_total;
	logic       last;

	// two copies of the lock: one follows accepted transfers, one plans stimulus
	mode_t       lk_mode [2];
	int unsigned lk_readers [2];
	id_t         rd_wait [2][RD_DEPTH];
	int unsigned rd_cnt [2];
	id_t         wr_wait [2][WR_DEPTH];
	int unsigned wr_cnt [2];

	reply_t   reply_buf [RESULT_LIMIT];
	int       reply_n;
	request_t requests_pending [$];
	reply_t   replies_due [$];

	int unsigned mismatches = 0;
	int unsigned items_done = 0;
	int unsigned items_total = 0;
	int unsigned results_seen = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	int unsigned idle_cycles = 0;
	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;

	reader_writer_lock_arbiter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.requester    (requester),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.target       (target),
		.outcome      (outcome),
		.prev_state   (prev_state),
		.reader_total (reader_total),
		.last         (last)
	);

	always #6 clk = ~clk;

	function automatic void post(id_t tgt, outcome_t oc, mode_t prev);
		if (reply_n < RESULT_LIMIT) begin
			reply_buf[reply_n].tgt = tgt;
			reply_buf[reply_n].oc = oc;
			reply_buf[reply_n].prev = prev;
			reply_buf[reply_n].total = '0;
			reply_buf[reply_n].fin = 1'b0;
			reply_n++;
		end
	endfunction

	function automatic void read_request(int s, id_t who, bit may_queue);
		if (lk_mode[s] != MODE_WRITE) begin
			if (lk_readers[s] >= MAX_READERS) begin
				post(who, OC_ERROR, lk_mode[s]);
			end else begin
				post(who, OC_GRANT, lk_mode[s]);
				lk_readers[s]++;
				lk_mode[s] = MODE_READ;
			end
		end else if (!may_queue) begin
			post(who, OC_REFUSED, lk_mode[s]);
		end else if (rd_cnt[s] >= RD_DEPTH) begin
			post(who, OC_ERROR, lk_mode[s]);
		end else begin
			rd_wait[s][rd_cnt[s]] = who;
			rd_cnt[s]++;
			post(who, OC_QUEUED, lk_mode[s]);
		end
	endfunction

	function automatic void write_request(int s, id_t who, bit may_queue);
		if (lk_mode[s] == MODE_FREE) begin
			lk_mode[s] = MODE_WRITE;
			post(who, OC_GRANT, MODE_FREE);
		end else if (!may_queue) begin
			post(who, OC_REFUSED, lk_mode[s]);
		end else if (wr_cnt[s] >= WR_DEPTH) begin
			post(who, OC_ERROR, lk_mode[s]);
		end else begin
			wr_wait[s][wr_cnt[s]] = who;
			wr_cnt[s]++;
			post(who, OC_QUEUED, lk_mode[s]);
		end
	endfunction

	function automatic void write_release(int s, id_t who);
		int unsigned n;
		if (lk_mode[s] != MODE_WRITE) begin
			post(who, OC_ERROR, lk_mode[s]);
		end else if (wr_cnt[s] != 0) begin
			wr_cnt[s]--;
			post(wr_wait[s][wr_cnt[s]], OC_WOKEN, MODE_WRITE);
		end else if (rd_cnt[s] != 0) begin
			// wake the oldest readers, bounded by the burst size and reader limit
			n = rd_cnt[s];
			if (n > RESULT_LIMIT)
				n = RESULT_LIMIT;
			if (n > MAX_READERS)
				n = MAX_READERS;
			for (int unsigned i = 0; i < n; i++)
				post(rd_wait[s][i], OC_WOKEN, MODE_WRITE);
			for (int unsigned i = n; i < rd_cnt[s]; i++)
				rd_wait[s][i - n] = rd_wait[s][i];
			rd_cnt[s] -= n;
			lk_readers[s] = n;
			lk_mode[s] = MODE_READ;
		end else begin
			lk_mode[s] = MODE_FREE;
			post(who, OC_RELEASED, MODE_WRITE);
		end
	endfunction

	function automatic void read_release(int s, id_t who);
		if (lk_mode[s] != MODE_READ || lk_readers[s] == 0) begin
			post(who, OC_ERROR, lk_mode[s]);
		end else begin
			lk_readers[s]--;
			if (lk_readers[s] != 0) begin
				post(who, OC_RELEASED, MODE_READ);
			end else if (wr_cnt[s] != 0) begin
				wr_cnt[s]--;
				lk_mode[s] = MODE_WRITE;
				post(wr_wait[s][wr_cnt[s]], OC_WOKEN, MODE_READ);
			end else begin
				lk_mode[s] = MODE_FREE;
				post(who, OC_RELEASED, MODE_READ);
			end
		end
	endfunction

	function automatic void serve_request(int s, cmd_t cmd, id_t who);
		reply_n = 0;
		case (cmd)
			CMD_LOCK_READ:    read_request(s, who, 1'b1);
			CMD_TRY_READ:     read_request(s, who, 1'b0);
			CMD_LOCK_WRITE:   write_request(s, who, 1'b1);
			CMD_TRY_WRITE:    write_request(s, who, 1'b0);
			CMD_READ_UNLOCK:  read_release(s, who);
			CMD_WRITE_UNLOCK: write_release(s, who);
			CMD_UNLOCK: begin
				if (lk_mode[s] == MODE_WRITE)
					write_release(s, who);
				else if (lk_mode[s] == MODE_READ)
					read_release(s, who);
				else
					post(who, OC_ERROR, lk_mode[s]);
			end
			default: begin
				// upgrade: sole reader takes the lock, another reader waits as a writer while the stack has room; else an error
				if (lk_mode[s] != MODE_READ || lk_readers[s] == 0) begin
					post(who, OC_ERROR, lk_mode[s]);
				end else if (lk_readers[s] == 1) begin
					lk_readers[s] = 0;
					lk_mode[s] = MODE_WRITE;
					post(who, OC_GRANT, MODE_READ);
				end else if (wr_cnt[s] >= WR_DEPTH) begin
					post(who, OC_ERROR, lk_mode[s]);
				end else begin
					lk_readers[s]--;
					wr_wait[s][wr_cnt[s]] = who;
					wr_cnt[s]++;
					post(who, OC_QUEUED, MODE_READ);
				end
			end
		endcase
		for (int k = 0; k < reply_n; k++) begin
			reply_buf[k].total = 8'(lk_readers[s]);
			reply_buf[k].fin = (k == reply_n - 1);
			if (s == LIVE)
				replies_due.insert(replies_due.size(), reply_buf[k]);
		end
	endfunction

	function automatic id_t any_id();
		return id_t'($urandom_range(0, REQUESTER_COUNT - 1));
	endfunction

	function automatic cmd_t any_read();
		return $urandom_range(0, 1) ? CMD_TRY_READ : CMD_LOCK_READ;
	endfunction

	function automatic void plan(cmd_t cmd, id_t who);
		request_t req;
		req = {cmd, who};
		requests_pending.insert(requests_pending.size(), req);
		serve_request(PLAN, cmd, who);
	endfunction

	// release holders until the planned lock is free
	function automatic void drain_plan();
		while (lk_mode[PLAN] != MODE_FREE) begin
			if (lk_mode[PLAN] == MODE_READ)
				plan($urandom_range(0, 1) ? CMD_UNLOCK : CMD_READ_UNLOCK, any_id());
			else
				plan($urandom_range(0, 1) ? CMD_UNLOCK : CMD_WRITE_UNLOCK, any_id());
		end
	endfunction

	// mostly requests that make sense for the current lock mode, some noise
	function automatic void random_step();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			plan(cmd_t'($urandom_range(0, 7)), any_id());
		end else if (lk_mode[PLAN] == MODE_FREE) begin
			case ($urandom_range(0, 3))
				0:       plan(CMD_LOCK_READ, any_id());
				1:       plan(CMD_TRY_READ, any_id());
				2:       plan(CMD_LOCK_WRITE, any_id());
				default: plan(CMD_TRY_WRITE, any_id());
			endcase
		end else if (lk_mode[PLAN] == MODE_READ) begin
			case ($urandom_range(0, 9))
				0, 1, 2: plan(lk_readers[PLAN] < 12 ? any_read() : CMD_READ_UNLOCK, any_id());
				3, 4, 5: plan($urandom_range(0, 1) ? CMD_UNLOCK : CMD_READ_UNLOCK, any_id());
				6:       plan(CMD_UPGRADE, any_id());
				7:       plan(CMD_LOCK_WRITE, any_id());
				default: plan(CMD_TRY_WRITE, any_id());
			endcase
		end else begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: plan(CMD_LOCK_READ, any_id());
				4, 5:       plan(CMD_LOCK_WRITE, any_id());
				6:          plan($urandom_range(0, 1) ? CMD_TRY_READ : CMD_TRY_WRITE, any_id());
				default:    plan($urandom_range(0, 1) ? CMD_UNLOCK : CMD_WRITE_UNLOCK, any_id());
			endcase
		end
	endfunction

	// every third stretch of 40 runs with no idling
	function automatic int unsigned pause_for(int unsigned idx);
		return ((idx / 40) % 3 == 1) ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		for (int s = 0; s < 2; s++) begin
			lk_mode[s] = MODE_FREE;
			lk_readers[s] = 0;
			rd_cnt[s] = 0;
			wr_cnt[s] = 0;
		end

		// unlocks and upgrade on a free lock
		plan(CMD_READ_UNLOCK, 8'h00);
		plan(CMD_WRITE_UNLOCK, 8'hFF);
		plan(CMD_UNLOCK, 8'h00);
		plan(CMD_UPGRADE, 8'hFF);
		// shared reading, writers wait, upgrades
		plan(CMD_TRY_READ, 8'h55);
		plan(CMD_LOCK_READ, 8'hAA);
		plan(CMD_TRY_WRITE, 8'h33);
		plan(CMD_LOCK_WRITE, 8'h0F);
		plan(CMD_UPGRADE, 8'hF0);
		plan(CMD_WRITE_UNLOCK, 8'h11);
		plan(CMD_UPGRADE, 8'h55);
		// writing, readers wait
		plan(CMD_TRY_READ, 8'hCC);
		plan(CMD_LOCK_READ, 8'h01);
		plan(CMD_LOCK_READ, 8'h02);
		plan(CMD_TRY_WRITE, 8'hFE);
		plan(CMD_READ_UNLOCK, 8'h7F);
		plan(CMD_UPGRADE, 8'h80);
		// hand-overs: newest writer first, then the readers together
		plan(CMD_WRITE_UNLOCK, 8'h55);
		plan(CMD_UNLOCK, 8'hF0);
		plan(CMD_UNLOCK, 8'h0F);
		plan(CMD_LOCK_READ, 8'hFF);
		plan(CMD_READ_UNLOCK, 8'h01);
		plan(CMD_UNLOCK, 8'h02);
		plan(CMD_READ_UNLOCK, 8'hFF);
		plan(CMD_LOCK_WRITE, 8'h80);
		plan(CMD_UNLOCK, 8'h80);

		repeat (20) random_step();

		// fill the writer stack under readers, then the reader fifo under a writer
		drain_plan();
		repeat ($urandom_range(2, 5)) plan(any_read(), any_id());
		while (wr_cnt[PLAN] < WR_DEPTH) plan(CMD_LOCK_WRITE, any_id());
		plan(CMD_LOCK_WRITE, any_id());
		plan(CMD_UPGRADE, any_id());
		while (lk_mode[PLAN] == MODE_READ) plan(CMD_READ_UNLOCK, any_id());
		while (rd_cnt[PLAN] < RD_DEPTH) plan(CMD_LOCK_READ, any_id());
		plan(CMD_LOCK_READ, any_id());

		// wake the stacked writers, then the full reader burst
		while (lk_mode[PLAN] == MODE_WRITE)
			plan($urandom_range(0, 1) ? CMD_UNLOCK : CMD_WRITE_UNLOCK, any_id());

		// reader saturation on top of the woken readers
		while (lk_readers[PLAN] < MAX_READERS) plan(any_read(), any_id());
		plan(CMD_TRY_READ, any_id());
		plan(CMD_LOCK_READ, any_id());
		plan(CMD_UPGRADE, any_id());
		plan(CMD_LOCK_READ, any_id());
		items_total = requests_pending.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (items_done < items_total || replies_due.size() != 0);
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// request driver
	always @(posedge clk) begin
		request_t next_req;
		logic     offer;
		if (arst_n) begin
			offer = in_valid;
			if (in_valid && in_ready) begin
				serve_request(LIVE, command, requester);
				items_done++;
				offer = 1'b0;
				tx_wait = pause_for(items_done);
			end
			if (!offer) begin
				if (tx_wait != 0) begin
					tx_wait--;
				end else if (requests_pending.size() != 0) begin
					next_req = requests_pending.pop_front();
					command <= next_req.cmd;
					requester <= next_req.who;
					offer = 1'b1;
				end
			end
			in_valid <= offer;
		end
	end

	// one long receiver stall so the block backs up and stalls its input
	always @(posedge clk) begin
		if (!hold_done && results_seen >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		reply_t want;
		if (out_valid && out_ready) begin
			if (replies_due.size() == 0) begin
				$display("%0t: result with nothing due: target %0d outcome %0d",
					$time, target, outcome);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				check_field("target", want.tgt, target);
				check_field("outcome", 8'(want.oc), 8'(outcome));
				check_field("prev_state", 8'(want.prev), 8'(prev_state));
				check_field("reader_total", want.total, reader_total);
				check_field("last", 8'(want.fin), 8'(last));
			end
			results_seen++;
			rx_wait = pause_for(results_seen);
		end else if (rx_wait != 0) begin
			rx_wait--;
		end
		out_ready <= (rx_wait == 0) && (hold_left == 0);
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
